// ===== rtl/wao_pkg.sv =====
`default_nettype none

package wao_pkg;

    localparam int COORD_W   = 12;
    localparam int CHAN_W    = 8;
    localparam int DIM_W     = 13;
    localparam int MROWS_W   = 8;
    localparam int MCOLS_W   = 9;
    localparam int ENTRY_W   = 32;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [DIM_W-1:0]   IMAGE_ROWS_RST = 13'd1080;
    localparam logic [DIM_W-1:0]   IMAGE_COLS_RST = 13'd1920;
    localparam logic [MROWS_W-1:0] MARK_ROWS_RST  = 8'd0;
    localparam logic [MCOLS_W-1:0] MARK_COLS_RST  = 9'd0;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam int MIX_SUM_W  = 11;
    localparam int MIX_PROD_W = 21;
    localparam int MIX_SHIFT  = 13;
    localparam logic [MIX_PROD_W-1:0] MIX_RECIP = 21'd1639;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IMAGE_ROWS     = 3'd0,
        REG_IMAGE_COLS     = 3'd1,
        REG_MARK_ROWS      = 3'd2,
        REG_MARK_COLS      = 3'd3,
        REG_OVERLAY_ENABLE = 3'd4
    } reg_idx_t;

    // (4*img + mark + 2) / 5, the divide done as a multiply by 1639/8192
    function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] img,
                                                      input logic [CHAN_W-1:0] mark);
        logic [MIX_SUM_W-1:0]  sum;
        logic [MIX_PROD_W-1:0] prod;
        sum  = {img, 2'b00} + MIX_SUM_W'(mark) + MIX_SUM_W'(2);
        prod = MIX_PROD_W'(sum) * MIX_RECIP;
        return prod[MIX_SHIFT +: CHAN_W];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wao_in_if.sv =====
`default_nettype none

interface wao_in_if
    import wao_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  mark_alpha;

    modport source (
        output valid, req_type, row, col, blue, green, red, mark_alpha,
        input  ready
    );
    modport sink (
        input  valid, req_type, row, col, blue, green, red, mark_alpha,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/wao_out_if.sv =====
`default_nettype none

interface wao_out_if
    import wao_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;
    logic              was_blended;

    modport source (
        output valid, out_blue, out_green, out_red, was_blended,
        input  ready
    );
    modport sink (
        input  valid, out_blue, out_green, out_red, was_blended,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/watermark_alpha_overlay_unit.sv =====
// Path: a pixel item passes the input register, the stage-2 lookup register and the result register.
// Throughput: one item per cycle while the output is not stalled; the watermark store
// has one port shared by loads and pixel lookups, each item using it once.
// Reset: asynchronous, active low; clears pipeline valids and sets the
// registers to their defaults. Store contents are undefined until loaded.
`default_nettype none

module watermark_alpha_overlay_unit
    import wao_pkg::*;
#(
    parameter int MAX_MARK_ROWS = 128,
    parameter int MAX_MARK_COLS = 256,
    parameter int MAX_IMAGE_DIM = 4096
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    wao_in_if.sink                     pixel_in,
    wao_out_if.source                  pixel_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int DEPTH  = MAX_MARK_ROWS * MAX_MARK_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW     = (MAX_MARK_ROWS > 1) ? $clog2(MAX_MARK_ROWS) : 1;
    localparam int CW     = (MAX_MARK_COLS > 1) ? $clog2(MAX_MARK_COLS) : 1;
    localparam int IDW    = ($clog2(MAX_IMAGE_DIM + 1) > DIM_W) ?
                            $clog2(MAX_IMAGE_DIM + 1) : DIM_W;

    // configuration
    logic [DIM_W-1:0]   image_rows_reg;
    logic [DIM_W-1:0]   image_cols_reg;
    logic [MROWS_W-1:0] mark_rows_reg;
    logic [MCOLS_W-1:0] mark_cols_reg;
    logic               overlay_enable_reg;
    logic               cfg_write;
    reg_idx_t           cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg     <= IMAGE_ROWS_RST;
            image_cols_reg     <= IMAGE_COLS_RST;
            mark_rows_reg      <= MARK_ROWS_RST;
            mark_cols_reg      <= MARK_COLS_RST;
            overlay_enable_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_IMAGE_ROWS:     image_rows_reg     <= pwdata[DIM_W-1:0];
                REG_IMAGE_COLS:     image_cols_reg     <= pwdata[DIM_W-1:0];
                REG_MARK_ROWS:      mark_rows_reg      <= pwdata[MROWS_W-1:0];
                REG_MARK_COLS:      mark_cols_reg      <= pwdata[MCOLS_W-1:0];
                REG_OVERLAY_ENABLE: overlay_enable_reg <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_IMAGE_ROWS:     prdata = APB_DATA_W'(image_rows_reg);
            REG_IMAGE_COLS:     prdata = APB_DATA_W'(image_cols_reg);
            REG_MARK_ROWS:      prdata = APB_DATA_W'(mark_rows_reg);
            REG_MARK_COLS:      prdata = APB_DATA_W'(mark_cols_reg);
            REG_OVERLAY_ENABLE: prdata = APB_DATA_W'(overlay_enable_reg);
            default:            prdata = '0;
        endcase
    end

    // pipeline handshake
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic res_valid_reg;
    logic adv_res;
    logic adv_s2;
    logic adv_s1;

    assign adv_res        = !res_valid_reg || pixel_out.ready;
    assign adv_s2         = !s2_valid_reg || adv_res;
    assign adv_s1         = !s1_valid_reg || adv_s2;
    assign pixel_in.ready = adv_s1;

    // stage 1: input register
    logic               s1_req_reg;
    logic [COORD_W-1:0] s1_row_reg;
    logic [COORD_W-1:0] s1_col_reg;
    logic [CHAN_W-1:0]  s1_blue_reg;
    logic [CHAN_W-1:0]  s1_green_reg;
    logic [CHAN_W-1:0]  s1_red_reg;
    logic [CHAN_W-1:0]  s1_alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv_s1)
            s1_valid_reg <= pixel_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv_s1 && pixel_in.valid)
        begin
            s1_req_reg   <= pixel_in.req_type;
            s1_row_reg   <= pixel_in.row;
            s1_col_reg   <= pixel_in.col;
            s1_blue_reg  <= pixel_in.blue;
            s1_green_reg <= pixel_in.green;
            s1_red_reg   <= pixel_in.red;
            s1_alpha_reg <= pixel_in.mark_alpha;
        end
    end

    // region test and store address
    logic [IDW-1:0]    row_x;
    logic [IDW-1:0]    col_x;
    logic [IDW-1:0]    img_rows_x;
    logic [IDW-1:0]    img_cols_x;
    logic [IDW-1:0]    irows;
    logic [IDW-1:0]    icols;
    logic [IDW-1:0]    mrows_x;
    logic [IDW-1:0]    mcols_x;
    logic [IDW-1:0]    r0;
    logic [IDW-1:0]    c0;
    logic [IDW-1:0]    mr_full;
    logic [IDW-1:0]    mc_full;
    logic              region_hit;
    logic              load_in_range;
    logic              mem_we;
    logic [ADDR_W-1:0] pix_addr;
    logic [ADDR_W-1:0] load_addr;
    logic [ADDR_W-1:0] mem_addr;
    logic [ENTRY_W-1:0] load_word;

    always_comb
    begin
        row_x      = IDW'(s1_row_reg);
        col_x      = IDW'(s1_col_reg);
        img_rows_x = IDW'(image_rows_reg);
        img_cols_x = IDW'(image_cols_reg);
        irows      = (img_rows_x > IDW'(MAX_IMAGE_DIM)) ? IDW'(MAX_IMAGE_DIM) : img_rows_x;
        icols      = (img_cols_x > IDW'(MAX_IMAGE_DIM)) ? IDW'(MAX_IMAGE_DIM) : img_cols_x;
        mrows_x    = IDW'(mark_rows_reg);
        mcols_x    = IDW'(mark_cols_reg);
        r0         = irows - mrows_x;
        c0         = icols - mcols_x;
        mr_full    = row_x - r0;
        mc_full    = col_x - c0;
        region_hit = overlay_enable_reg
                  && (mrows_x != '0) && (mcols_x != '0)
                  && (mrows_x <= IDW'(MAX_MARK_ROWS))
                  && (mcols_x <= IDW'(MAX_MARK_COLS))
                  && (mrows_x <= irows) && (mcols_x <= icols)
                  && (row_x < irows) && (col_x < icols)
                  && (row_x >= r0) && (col_x >= c0);
        pix_addr   = ADDR_W'(mr_full[RW-1:0]) * ADDR_W'(MAX_MARK_COLS)
                   + ADDR_W'(mc_full[CW-1:0]);
        load_addr  = ADDR_W'(s1_row_reg[RW-1:0]) * ADDR_W'(MAX_MARK_COLS)
                   + ADDR_W'(s1_col_reg[CW-1:0]);
        load_in_range = (IDW'(s1_row_reg) < IDW'(MAX_MARK_ROWS))
                     && (IDW'(s1_col_reg) < IDW'(MAX_MARK_COLS));
        mem_addr   = (s1_req_reg == REQ_PIXEL) ? pix_addr : load_addr;
        load_word  = {s1_alpha_reg, s1_red_reg, s1_green_reg, s1_blue_reg};
        mem_we     = s1_valid_reg && adv_s2 && (s1_req_reg == REQ_LOAD) && load_in_range;
    end

    // watermark store
    logic [ENTRY_W-1:0] mark_store [DEPTH];
    logic [ENTRY_W-1:0] s2_entry_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mark_store[mem_addr] <= load_word;
    end

    always_ff @(posedge clk)
    begin
        if (adv_s2)
            s2_entry_reg <= mark_store[mem_addr];
    end

    // stage 2: pixel with lookup result
    logic              s2_hit_reg;
    logic [CHAN_W-1:0] s2_blue_reg;
    logic [CHAN_W-1:0] s2_green_reg;
    logic [CHAN_W-1:0] s2_red_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv_s2)
            s2_valid_reg <= s1_valid_reg && (s1_req_reg == REQ_PIXEL);
    end

    always_ff @(posedge clk)
    begin
        if (adv_s2)
        begin
            s2_hit_reg   <= region_hit;
            s2_blue_reg  <= s1_blue_reg;
            s2_green_reg <= s1_green_reg;
            s2_red_reg   <= s1_red_reg;
        end
    end

    // blend
    logic              blend;
    logic [CHAN_W-1:0] blue_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] red_next;

    always_comb
    begin
        blend      = s2_hit_reg && (s2_entry_reg[31:24] != '0);
        blue_next  = blend ? mix_channel(s2_blue_reg,  s2_entry_reg[7:0])   : s2_blue_reg;
        green_next = blend ? mix_channel(s2_green_reg, s2_entry_reg[15:8])  : s2_green_reg;
        red_next   = blend ? mix_channel(s2_red_reg,   s2_entry_reg[23:16]) : s2_red_reg;
    end

    // stage 3: result register
    logic [CHAN_W-1:0] res_blue_reg;
    logic [CHAN_W-1:0] res_green_reg;
    logic [CHAN_W-1:0] res_red_reg;
    logic              res_blended_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (adv_res)
            res_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv_res && s2_valid_reg)
        begin
            res_blue_reg    <= blue_next;
            res_green_reg   <= green_next;
            res_red_reg     <= red_next;
            res_blended_reg <= blend;
        end
    end

    assign pixel_out.valid       = res_valid_reg;
    assign pixel_out.out_blue    = res_blue_reg;
    assign pixel_out.out_green   = res_green_reg;
    assign pixel_out.out_red     = res_red_reg;
    assign pixel_out.was_blended = res_blended_reg;

    // checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> pixel_in.ready)
        else $error("input stalled with empty result stage");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_req_reg == REQ_LOAD) && adv_s2) |=> !s2_valid_reg)
        else $error("load item moved on as a pixel");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !pixel_out.ready && s2_valid_reg) |=> s2_valid_reg)
        else $error("stage 2 item dropped during output stall");

endmodule

`default_nettype wire
